/* src/ble_message_reassembler_assert.svh */
// Assertion macros shared by the checker of the message reassembler.
`ifndef BLE_MESSAGE_REASSEMBLER_ASSERT_SVH
`define BLE_MESSAGE_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, clocked on clk, held off while rst_n is low.
`define BMR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmr check failed");

// Next-cycle implication, clocked on clk, held off while rst_n is low.
`define BMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmr check failed");

`endif

/* src/bmr_pkg.sv */
// Package of the message reassembler: status codes, sizes and stream field positions.
package bmr_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_NONE       = 3'd0;
    localparam status_t ST_OK         = 3'd1;
    localparam status_t ST_COMPLETE   = 3'd2;
    localparam status_t ST_SHORT_INIT = 3'd3;
    localparam status_t ST_SHORT_CONT = 3'd4;
    localparam status_t ST_SEQ_ERR    = 3'd5;
    localparam status_t ST_OVERFLOW   = 3'd6;

    localparam int DEFAULT_MAX_FRAME_BYTES = 512;
    localparam int INDEX_CAP               = 1023;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int SEQ_W    = 7;

    // Result tdata layout, lowest bit first
    localparam int PB_LSB   = 0;
    localparam int PO_LSB   = PB_LSB + BYTE_W;
    localparam int ST_LSB   = PO_LSB + OFFSET_W;
    localparam int CMD_LSB  = ST_LSB + 3;
    localparam int LEN_LSB  = CMD_LSB + BYTE_W;
    localparam int RES_BITS = LEN_LSB + OFFSET_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

endpackage

/* src/ble_message_reassembler.sv */
// Top level of the message reassembler: header parsing, sequence check and payload placement.
//
//  channel      | dir | handshake              | contents
//  -------------+-----+------------------------+---------------------------------------------
//  s_axis       | in  | s_axis_tvalid/tready   | tdata: rx_byte, tlast: frame_last
//  m_axis       | out | m_axis_tvalid/tready   | tdata: byte, offset, status, command, length
//               |     |                        | tlast: frame_done, tuser: payload_valid
//
// One item in, one result out, one cycle each: every received byte is decoded in the
// cycle it is accepted and its result lands in the output stage on the same edge.
// Sustained rate is one item per cycle while the output takes results; a two-entry output
// stage (result register plus skid register) lets the input take one more item on a stall.
// Reset (rst_n low, asynchronous) waits for an initial frame and clears all counters.
// s_axis_tready comes straight from a register: low only while the skid entry is full.
module ble_message_reassembler
    import bmr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    input  logic             s_axis_tlast,   // frame_last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [7:0] payload_byte, [23:8] payload_offset, [26:24] frame_status,
    // [34:27] command, [50:35] message_length, [55:51] zero
    output logic [RES_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast,   // frame_done
    output logic             m_axis_tuser    // payload_valid
);

    // Byte index saturates here; only 0, 1, 2 and beyond matter to the decode.
    localparam int IDX_LIMIT = (MAX_FRAME_BYTES - 1 > INDEX_CAP) ? INDEX_CAP
                                                                 : MAX_FRAME_BYTES - 1;
    localparam int IDX_W     = $clog2(IDX_LIMIT + 1);

    typedef struct packed {
        logic [RES_W-1:0] data;
        logic             done;
        logic             pvalid;
    } result_t;

    // Frame and message state
    logic                expect_initial_reg, expect_initial_next;
    logic [IDX_W-1:0]    index_reg,          index_next;
    logic [BYTE_W-1:0]   command_reg,        command_next;
    logic [BYTE_W-1:0]   length_high_reg,    length_high_next;
    logic [OFFSET_W-1:0] declared_reg,       declared_next;
    logic [OFFSET_W-1:0] offset_reg,         offset_next;
    logic [SEQ_W-1:0]    sequence_reg,       sequence_next;
    status_t             pending_reg,        pending_next;

    // Output stage
    result_t result_reg, skid_reg, result_new;
    logic    result_valid_reg, skid_valid_reg;

    logic          accept;
    logic          take;
    logic          pv;
    logic [BYTE_W-1:0]   pb;
    logic [OFFSET_W-1:0] po;
    status_t       status;
    status_t       short_err;
    logic          payload;
    logic          last;
    logic [BYTE_W-1:0] rx;

    assign rx     = s_axis_tdata;
    assign last   = s_axis_tlast;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign take   = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = !skid_valid_reg;

    // Decode one byte against the frame state
    always_comb
    begin
        expect_initial_next = expect_initial_reg;
        index_next          = index_reg;
        command_next        = command_reg;
        length_high_next    = length_high_reg;
        declared_next       = declared_reg;
        offset_next         = offset_reg;
        sequence_next       = sequence_reg;
        pending_next        = pending_reg;
        short_err           = ST_NONE;
        payload             = 1'b0;
        pv                  = 1'b0;
        pb                  = '0;
        po                  = '0;
        status              = ST_NONE;

        if (expect_initial_reg)
        begin
            if (index_reg == IDX_W'(0))
            begin
                command_next = rx;
                if (last)
                begin
                    short_err = ST_SHORT_INIT;
                end
            end
            else if (index_reg == IDX_W'(1))
            begin
                length_high_next = rx;
                if (last)
                begin
                    short_err = ST_SHORT_INIT;
                end
            end
            else if (index_reg == IDX_W'(2))
            begin
                // Length complete: start a fresh message
                declared_next = {length_high_reg, rx};
                offset_next   = '0;
                sequence_next = '0;
            end
            else
            begin
                payload = 1'b1;
            end
        end
        else
        begin
            if (index_reg == IDX_W'(0))
            begin
                if (last)
                begin
                    short_err = ST_SHORT_CONT;
                end
                else if (pending_reg == ST_NONE && rx != {1'b0, sequence_reg})
                begin
                    pending_next = ST_SEQ_ERR;
                end
                else if (pending_reg == ST_NONE)
                begin
                    sequence_next = sequence_reg + SEQ_W'(1);
                end
            end
            else
            begin
                payload = 1'b1;
            end
        end

        // Place payload; drop it and flag overflow once the length is used up
        if (payload && pending_next == ST_NONE)
        begin
            if (offset_next < declared_next)
            begin
                pv          = 1'b1;
                pb          = rx;
                po          = offset_next;
                offset_next = offset_next + OFFSET_W'(1);
            end
            else
            begin
                pending_next = ST_OVERFLOW;
            end
        end

        if (last)
        begin
            if (short_err != ST_NONE)
            begin
                status = short_err;
            end
            else if (pending_next != ST_NONE)
            begin
                status = pending_next;
            end
            else if (offset_next == declared_next)
            begin
                status = ST_COMPLETE;
            end
            else
            begin
                status = ST_OK;
            end
            // Any status but ST_OK, even ST_COMPLETE, sends us back to await an initial frame
            expect_initial_next = (status != ST_OK);
            index_next          = '0;
            pending_next        = ST_NONE;
        end
        else if (index_reg < IDX_W'(IDX_LIMIT))
        begin
            index_next = index_reg + IDX_W'(1);
        end

        result_new.pvalid = pv;
        result_new.done   = last;
        result_new.data   = RES_W'({declared_next, command_next, status, po, pb});
    end

    // Advance frame state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_initial_reg <= 1'b1;
            index_reg          <= '0;
            command_reg        <= '0;
            length_high_reg    <= '0;
            declared_reg       <= '0;
            offset_reg         <= '0;
            sequence_reg       <= '0;
            pending_reg        <= ST_NONE;
        end
        else if (accept)
        begin
            expect_initial_reg <= expect_initial_next;
            index_reg          <= index_next;
            command_reg        <= command_next;
            length_high_reg    <= length_high_next;
            declared_reg       <= declared_next;
            offset_reg         <= offset_next;
            sequence_reg       <= sequence_next;
            pending_reg        <= pending_next;
        end
    end

    // Output stage: result register backed by one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!result_valid_reg || take)
            begin
                result_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Payload of the output stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                result_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!result_valid_reg || take)
            begin
                result_reg <= result_new;
            end
            else
            begin
                skid_reg <= result_new;
            end
        end
    end

    assign m_axis_tvalid = result_valid_reg;
    assign m_axis_tdata  = result_reg.data;
    assign m_axis_tlast  = result_reg.done;
    assign m_axis_tuser  = result_reg.pvalid;

endmodule

/* src/bmr_checker.sv */
// Port-level checker of the message reassembler and its bind.
`include "ble_message_reassembler_assert.svh"

module bmr_checker
    import bmr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [7:0]       s_axis_tdata,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [RES_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             m_axis_tuser
);

    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] length;
    status_t             status;
    logic [PO_LSB+OFFSET_W-1:0] payload_bits;
    logic                in_accept;

    assign offset       = m_axis_tdata[PO_LSB +: OFFSET_W];
    assign length       = m_axis_tdata[LEN_LSB +: OFFSET_W];
    assign status       = m_axis_tdata[ST_LSB +: 3];
    assign payload_bits = m_axis_tdata[PO_LSB+OFFSET_W-1:0];
    assign in_accept    = s_axis_tvalid && s_axis_tready;

    // A placed payload byte always lies inside the declared message
    `BMR_ASSERT_SAME(a_offset_in_range, m_axis_tvalid && m_axis_tuser, offset < length)
    // Byte and offset read zero when no payload is carried
    `BMR_ASSERT_SAME(a_idle_payload_zero, m_axis_tvalid && !m_axis_tuser, payload_bits == '0)
    // Status is reported on the frame end and only there
    `BMR_ASSERT_SAME(a_status_on_end, m_axis_tvalid,
                     (m_axis_tlast == (status != ST_NONE)) && status != 3'd7)
    // Stalled result holds
    `BMR_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                     && $stable(m_axis_tuser))
    // An item taken into an empty output stage shows up next cycle with its frame end
    // and, when it is payload, its own byte
    `BMR_ASSERT_NEXT(a_direct_load, in_accept && !m_axis_tvalid,
                     m_axis_tvalid && m_axis_tlast == $past(s_axis_tlast)
                     && (!m_axis_tuser || m_axis_tdata[PB_LSB +: BYTE_W] == $past(s_axis_tdata)))

endmodule

bind ble_message_reassembler bmr_checker u_bmr_checker (.*);

/* bench/ble_message_reassembler_tb.sv */
// Self-checking testbench of the message reassembler: directed frames, then random messages.
`timescale 1ns / 1ps

module ble_message_reassembler_tb;
    import bmr_pkg::*;

    // Byte index ceiling of the default build: MAX_FRAME_BYTES - 1, held to the hard cap
    localparam int IDX_CEIL = (DEFAULT_MAX_FRAME_BYTES - 1 > INDEX_CAP) ?
                              INDEX_CAP : DEFAULT_MAX_FRAME_BYTES - 1;

    // One verdict per received byte, in the order the block reports it
    typedef struct packed {
        logic          pv;     // payload_valid
        logic [7:0]    pb;     // payload_byte
        logic [15:0]   po;     // payload_offset
        logic          done;   // frame_done
        status_t       st;     // frame_status
        logic [7:0]    cmd;    // command
        logic [15:0]   len;    // message_length
    } verdict_t;

    // Directed row: one received byte, with its verdict typed in where it is obvious
    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed_in;
        verdict_t      verdict;
    } probe_row_t;

    // Mirror of the reassembler's state
    typedef struct {
        bit            want_header;
        int unsigned   byte_idx;
        logic [7:0]    cmd;
        logic [7:0]    len_hi;
        logic [15:0]   length;
        logic [16:0]   offset;
        logic [6:0]    seq;
        status_t       pending;
    } link_state_t;

    // Ways of breaking a generated message
    typedef enum int {
        FAULT_NONE,
        FAULT_SHORT_INIT,
        FAULT_SHORT_CONT,
        FAULT_BAD_SEQ,
        FAULT_OVERFLOW,
        FAULT_TRUNCATE
    } fault_t;

    localparam verdict_t NIL_V = '0;

    // Directed frames, walked in order straight after reset:
    // short initial on its first byte, short initial on its second byte, empty message,
    // maximum length with one payload byte, short continuation, overflow past length 1,
    // initial frame of length 0x0100, then a continuation whose sequence byte has bit 7 set.
    localparam int PROBE_COUNT = 22;
    localparam probe_row_t PROBES [PROBE_COUNT] = '{
        '{8'hA5, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, ST_SHORT_INIT, 8'hA5, 16'h0000}},
        '{8'hFF, 1'b0, 1'b0, NIL_V},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, ST_SHORT_INIT, 8'hFF, 16'h0000}},
        '{8'h00, 1'b0, 1'b0, NIL_V},
        '{8'h00, 1'b0, 1'b0, NIL_V},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, ST_COMPLETE, 8'h00, 16'h0000}},
        '{8'h81, 1'b0, 1'b0, NIL_V},
        '{8'hFF, 1'b0, 1'b0, NIL_V},
        '{8'hFF, 1'b0, 1'b0, NIL_V},
        '{8'h5A, 1'b1, 1'b1, '{1'b1, 8'h5A, 16'h0000, 1'b1, ST_OK, 8'h81, 16'hFFFF}},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, ST_SHORT_CONT, 8'h81, 16'hFFFF}},
        '{8'h7E, 1'b0, 1'b0, NIL_V},
        '{8'h00, 1'b0, 1'b0, NIL_V},
        '{8'h01, 1'b0, 1'b0, NIL_V},
        '{8'hAB, 1'b0, 1'b1, '{1'b1, 8'hAB, 16'h0000, 1'b0, ST_NONE, 8'h7E, 16'h0001}},
        '{8'hCD, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, ST_OVERFLOW, 8'h7E, 16'h0001}},
        '{8'h01, 1'b0, 1'b0, NIL_V},
        '{8'h01, 1'b0, 1'b0, NIL_V},
        '{8'h00, 1'b0, 1'b0, NIL_V},
        '{8'h33, 1'b1, 1'b1, '{1'b1, 8'h33, 16'h0000, 1'b1, ST_OK, 8'h01, 16'h0100}},
        '{8'h80, 1'b0, 1'b0, NIL_V},
        '{8'h44, 1'b1, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, ST_SEQ_ERR, 8'h01, 16'h0100}}
    };

    logic               clk;
    logic               rst_n          = 1'b0;
    logic               s_axis_tvalid  = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata   = 8'h00;
    logic               s_axis_tlast   = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready  = 1'b1;
    logic [RES_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;

    link_state_t        link;
    verdict_t           due_verdicts[$];
    int unsigned        bad_fields = 0;
    int unsigned        bytes_sent = 0;
    bit                 calm       = 1'b0;   // no random input gaps or output stalls once set

    ble_message_reassembler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Decode one received byte against the mirrored state and return its verdict
    function automatic verdict_t decode_rx_byte(input logic [7:0] data, input logic last);
        verdict_t    v;
        status_t     short_st;
        bit          payload;
        int unsigned idx;
        v        = '0;
        short_st = ST_NONE;
        payload  = 1'b0;
        idx      = link.byte_idx;

        if (link.want_header)
        begin
            // Header bytes land in the state even when the frame stops early
            case (idx)
                0:
                begin
                    link.cmd = data;
                    if (last)
                        short_st = ST_SHORT_INIT;
                end
                1:
                begin
                    link.len_hi = data;
                    if (last)
                        short_st = ST_SHORT_INIT;
                end
                2:
                begin
                    link.length = {link.len_hi, data};
                    link.offset = '0;
                    link.seq    = '0;
                end
                default:
                    payload = 1'b1;
            endcase
        end
        else if (idx == 0)
        begin
            // Sequence byte: anything above 0x7f can never match the 7-bit counter
            if (last)
                short_st = ST_SHORT_CONT;
            else if (link.pending == ST_NONE && data != {1'b0, link.seq})
                link.pending = ST_SEQ_ERR;
            else if (link.pending == ST_NONE)
                link.seq = link.seq + 7'd1;
        end
        else
            payload = 1'b1;

        // Place payload below the declared length; the first byte past it poisons the frame
        if (payload && link.pending == ST_NONE)
        begin
            if (link.offset < {1'b0, link.length})
            begin
                v.pv        = 1'b1;
                v.pb        = data;
                v.po        = link.offset[15:0];
                link.offset = link.offset + 17'd1;
            end
            else
                link.pending = ST_OVERFLOW;
        end

        if (last)
        begin
            v.done = 1'b1;
            if (short_st != ST_NONE)
                v.st = short_st;
            else if (link.pending != ST_NONE)
                v.st = link.pending;
            else if (link.offset == {1'b0, link.length})
                v.st = ST_COMPLETE;
            else
                v.st = ST_OK;
            // Any status but ST_OK, even ST_COMPLETE, sends the block back to hunting for a header
            link.want_header = (v.st != ST_OK);
            link.byte_idx    = 0;
            link.pending     = ST_NONE;
        end
        else if (idx < IDX_CEIL)
            link.byte_idx = idx + 1;

        v.cmd = link.cmd;
        v.len = link.length;
        return v;
    endfunction

    // Offer one byte at the falling edge, hold it until taken, then log its verdict.
    // Enter and leave at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic last,
                             input logic typed_in, input verdict_t typed_v);
        verdict_t v;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        v = decode_rx_byte(data, last);
        due_verdicts.push_back(typed_in ? typed_v : v);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send a whole frame, marking its final byte
    task automatic send_frame(input logic [7:0] fr[$]);
        foreach (fr[i])
            send_byte(fr[i], i == fr.size() - 1, 1'b0, NIL_V);
    endtask

    // Hold the sender off until every verdict owed has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (due_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // Push random bytes into frame-sized runs
    task automatic append_random(ref logic [7:0] fr[$], input int unsigned n);
        repeat (n)
            fr.push_back(8'($urandom_range(0, 255)));
    endtask

    // Build and send one message of the given length, chopped into frames of up to
    // chunk_max payload bytes, optionally broken in the way that fault names
    task automatic send_message(input int unsigned len, input int unsigned first_min,
                                input int unsigned chunk_max, input fault_t fault);
        logic [7:0]  fr[$];
        logic [7:0]  bad;
        logic [6:0]  seq;
        int unsigned left;
        int unsigned k;
        int          cut;
        fr = {};
        fr.push_back(8'($urandom_range(0, 255)));
        if (fault == FAULT_SHORT_INIT)
        begin
            if ($urandom_range(0, 1))
                fr.push_back(len[15:8]);
            send_frame(fr);
            return;
        end
        fr.push_back(len[15:8]);
        fr.push_back(len[7:0]);
        left = len;
        seq  = '0;
        cut  = $urandom_range(0, 3);
        k    = $urandom_range(first_min, chunk_max);
        if (k > left)
            k = left;
        append_random(fr, k);
        left -= k;
        forever
        begin
            if (left == 0 && fault == FAULT_OVERFLOW)
                append_random(fr, $urandom_range(1, 3));
            send_frame(fr);
            if (left == 0)
                return;
            fr = {};
            if (cut == 0)
            begin
                // On a SHORT_CONT, BAD_SEQ or TRUNCATE fault, break the message here and drop the rest
                case (fault)
                    FAULT_SHORT_CONT:
                    begin
                        append_random(fr, 1);
                        send_frame(fr);
                        return;
                    end
                    FAULT_BAD_SEQ:
                    begin
                        bad = 8'($urandom_range(0, 255));
                        if (bad == {1'b0, seq})
                            bad = bad ^ 8'h80;
                        fr.push_back(bad);
                        append_random(fr, $urandom_range(1, 4));
                        send_frame(fr);
                        return;
                    end
                    FAULT_TRUNCATE:
                        return;
                    default:
                        ;
                endcase
            end
            cut--;
            fr.push_back({1'b0, seq});
            seq = seq + 7'd1;
            k   = $urandom_range(1, chunk_max);
            if (k > left)
                k = left;
            append_random(fr, k);
            left -= k;
        end
    endtask

    // A short run of junk frames: arbitrary bytes and frame ends
    task automatic send_noise();
        logic [7:0] fr[$];
        repeat ($urandom_range(1, 3))
        begin
            fr = {};
            append_random(fr, $urandom_range(1, 5));
            send_frame(fr);
        end
    endtask

    // Draw one random message: mostly well-formed, some broken, some junk
    task automatic send_random_message();
        int unsigned len;
        int unsigned pick;
        fault_t      fault;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            send_noise();
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = $urandom_range(0, 65535);
        else if (pick < 25)
            len = $urandom_range(0, 3);
        else
            len = $urandom_range(0, 60);
        fault = FAULT_NONE;
        if ($urandom_range(0, 99) < 25)
            fault = fault_t'($urandom_range(FAULT_SHORT_INIT, FAULT_TRUNCATE));
        // Never play out a huge message in full: cut it off after a few frames
        if (len > 300 && (fault == FAULT_NONE || fault == FAULT_OVERFLOW))
            fault = FAULT_TRUNCATE;
        send_message(len, 0, 16, fault);
    endtask

    // Compare one field of a verdict and log any difference
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            bad_fields++;
        end
    endtask

    // Sample results at the rising edge and hold them up against the oldest verdict due
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_verdicts.size() == 0)
            begin
                $error("result with no byte outstanding");
                bad_fields++;
            end
            else
            begin
                want = due_verdicts.pop_front();
                check_field("payload_valid", 32'(want.pv), 32'(m_axis_tuser));
                check_field("payload_byte", 32'(want.pb),
                            32'(m_axis_tdata[PB_LSB +: BYTE_W]));
                check_field("payload_offset", 32'(want.po),
                            32'(m_axis_tdata[PO_LSB +: OFFSET_W]));
                check_field("frame_done", 32'(want.done), 32'(m_axis_tlast));
                check_field("frame_status", 32'(want.st), 32'(m_axis_tdata[ST_LSB +: 3]));
                check_field("command", 32'(want.cmd), 32'(m_axis_tdata[CMD_LSB +: BYTE_W]));
                check_field("message_length", 32'(want.len),
                            32'(m_axis_tdata[LEN_LSB +: OFFSET_W]));
                check_field("tdata padding", '0, 32'(m_axis_tdata[RES_W-1:RES_BITS]));
            end
        end
    end

    // Result side: stall in random bursts until the final stretch
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned rand_start;
        bit          specials_done;
        link = '{want_header: 1'b1, byte_idx: 0, cmd: '0, len_hi: '0, length: '0,
                 offset: '0, seq: '0, pending: ST_NONE};
        specials_done = 1'b0;

        // Hold reset, then release it away from the clock edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames
        for (int i = 0; i < PROBE_COUNT; i++)
            send_byte(PROBES[i].data, PROBES[i].last, PROBES[i].typed_in, PROBES[i].verdict);
        drain();

        // Random messages; partway through, run a sequence-wrapping message and a frame
        // long enough to pin the byte index at its ceiling
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 830)
        begin
            if (!specials_done && bytes_sent - rand_start >= 30)
            begin
                send_message(140, 0, 1, FAULT_NONE);
                send_message(530, 515, 530, FAULT_NONE);
                specials_done = 1'b1;
            end
            send_random_message();
            if ($urandom_range(0, 24) == 0)
                drain();
            if (bytes_sent - rand_start >= 760)
                calm = 1'b1;
        end

        // Stop sending, wait for the last verdicts, then watch for stray results
        s_axis_tvalid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (bad_fields == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/bmr_pkg.sv
src/ble_message_reassembler.sv
src/bmr_checker.sv
bench/ble_message_reassembler_tb.sv
